@@ rtl/core/lfmc_pkg.sv @@
// Package for the leg force to motor current pipeline: payload type,
// CORDIC tables, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package lfmc_pkg;

    localparam int NUM_STAGES   = 28;
    localparam int CORDIC_STEPS = 14;

    localparam logic [17:0]        PHASE_SCALE  = 18'd166886;
    localparam logic signed [17:0] CORDIC_START = 18'sd9949;
    localparam logic signed [17:0] UNIT_Q14     = 18'sd16384;

    localparam logic signed [16:0] ATAN_PHASE [CORDIC_STEPS] = '{
        17'sd8192, 17'sd4836, 17'sd2555, 17'sd1297, 17'sd651, 17'sd326, 17'sd163,
        17'sd81, 17'sd41, 17'sd20, 17'sd10, 17'sd5, 17'sd3, 17'sd1
    };

    localparam logic signed [43:0] ED_LIMIT = 44'sd4294967295;

    localparam logic [2:0] REG_PROP_GAIN        = 3'd0;
    localparam logic [2:0] REG_DERIV_GAIN       = 3'd1;
    localparam logic [2:0] REG_SPRING_STIFFNESS = 3'd2;
    localparam logic [2:0] REG_INV_STIFFNESS    = 3'd3;
    localparam logic [2:0] REG_INV_GEAR_GAIN    = 3'd4;
    localparam logic [2:0] REG_INV_TORQUE_CONST = 3'd5;

    localparam logic [31:0] RST_PROP_GAIN        = 32'd65536000;
    localparam logic [31:0] RST_DERIV_GAIN       = 32'd524288;
    localparam logic [31:0] RST_SPRING_STIFFNESS = 32'd269877248;
    localparam logic [31:0] RST_INV_STIFFNESS    = 32'd1042974;
    localparam logic [31:0] RST_INV_GEAR_GAIN    = 32'd85899345;
    localparam logic [31:0] RST_INV_TORQUE_CONST = 32'd169981935;

    typedef struct packed {
        logic               half;
        logic signed [23:0] fx;
        logic signed [23:0] fz;
        logic signed [31:0] dfx;
        logic signed [31:0] dfz;
        logic signed [16:0] w;
        logic signed [16:0] d;
        logic signed [16:0] dd;
    } lfmc_pay_t;

endpackage

@@ rtl/core/leg_force_to_motor_current.sv @@
// Leg force to motor current: one fully pipelined datapath from force request
// to saturated motor current. Depends on lfmc_pkg.
`timescale 1ns / 1ps

// An accepted input request passes through 28 register stages before its
// result can be taken on m_*. One request per cycle while the output is not
// stalled; every stage has its own valid bit and advances whenever it is
// empty or the stage after it moves, so bubbles close up while the output
// waits.
// Reset (aresetn low, synchronous) clears all valid bits and loads the gain
// registers with their default values. Data registers are not reset.
module leg_force_to_motor_current (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_leg_half,
    input  logic signed [23:0]  s_force_x,
    input  logic signed [23:0]  s_force_z,
    input  logic signed [31:0]  s_force_x_rate,
    input  logic signed [31:0]  s_force_z_rate,
    input  logic signed [15:0]  s_leg_angle,
    input  logic signed [15:0]  s_motor_angle,
    input  logic signed [15:0]  s_leg_rate,
    input  logic signed [15:0]  s_motor_rate,
    input  logic signed [15:0]  s_body_pitch,
    input  logic signed [15:0]  s_body_pitch_rate,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_result_half,
    output logic signed [15:0]  m_motor_current,
    output logic                m_current_clipped
);
    import lfmc_pkg::*;

    // Stage map: 0 phase multiply, 1..14 CORDIC steps, 15 quadrant mapping,
    // 16 force products, 17 torque sums, 18..26 gain arithmetic, 27 output.
    localparam int ST_TRIG = 1 + CORDIC_STEPS;
    localparam int ST_LAST = NUM_STAGES - 1;

    // Config regs: user must write only while the pipeline is idle; unchecked.
    logic [31:0] kp_reg, kd_reg, ks_reg, inv_ks_reg, inv_kg_reg, inv_kt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg     <= RST_PROP_GAIN;
            kd_reg     <= RST_DERIV_GAIN;
            ks_reg     <= RST_SPRING_STIFFNESS;
            inv_ks_reg <= RST_INV_STIFFNESS;
            inv_kg_reg <= RST_INV_GEAR_GAIN;
            inv_kt_reg <= RST_INV_TORQUE_CONST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:        kp_reg     <= cfg_data;
                REG_DERIV_GAIN:       kd_reg     <= cfg_data;
                REG_SPRING_STIFFNESS: ks_reg     <= cfg_data;
                REG_INV_STIFFNESS:    inv_ks_reg <= cfg_data;
                REG_INV_GEAR_GAIN:    inv_kg_reg <= cfg_data;
                REG_INV_TORQUE_CONST: inv_kt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control. A stage loads when it is empty or its successor loads.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] adv;
    lfmc_pay_t             pay_reg [NUM_STAGES];

    assign adv[ST_LAST] = !vld_reg[ST_LAST] || m_ready;
    genvar g;
    generate
        for (g = 0; g < ST_LAST; g++) begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate

    assign s_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 0: the angle th = leg + pitch becomes a 16-bit phase
    // (65536 per turn), rounded with ties upward.
    logic signed [16:0] th;
    logic signed [35:0] ph_sum;
    logic [15:0]        phase_reg;
    lfmc_pay_t          pay_in;

    assign th     = 17'(s_leg_angle) + 17'(s_body_pitch);
    assign ph_sum = 36'(th) * $signed({1'b0, PHASE_SCALE}) + 36'sd32768;

    always_comb begin
        pay_in.half = s_leg_half;
        pay_in.fx   = s_force_x;
        pay_in.fz   = s_force_z;
        pay_in.dfx  = s_force_x_rate;
        pay_in.dfz  = s_force_z_rate;
        pay_in.w    = 17'(s_leg_rate) + 17'(s_body_pitch_rate);
        pay_in.d    = 17'(s_motor_angle) - 17'(s_leg_angle);
        pay_in.dd   = 17'(s_motor_rate) - 17'(s_leg_rate);
    end

    // The payload shift register is loaded here as a whole, stage 0 from
    // the input ports and every later stage from the one before it.
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            phase_reg  <= ph_sum[31:16];
            pay_reg[0] <= pay_in;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                pay_reg[k] <= pay_reg[k-1];
            end
        end
    end

    // Stages 1..14: one CORDIC rotation per stage on the low 14 phase bits.
    // The quadrant bits ride along for the mapping afterwards.
    logic signed [17:0] cx_in  [CORDIC_STEPS];
    logic signed [17:0] cy_in  [CORDIC_STEPS];
    logic signed [16:0] cz_in  [CORDIC_STEPS];
    logic [1:0]         cq_in  [CORDIC_STEPS];
    logic signed [17:0] cx_reg [CORDIC_STEPS];
    logic signed [17:0] cy_reg [CORDIC_STEPS];
    logic signed [16:0] cz_reg [CORDIC_STEPS];
    logic [1:0]         cq_reg [CORDIC_STEPS];

    generate
        for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
            logic signed [17:0] dx, dy;
            if (g == 0) begin : g_init
                assign cx_in[g] = CORDIC_START;
                assign cy_in[g] = '0;
                assign cz_in[g] = {3'b000, phase_reg[13:0]};
                assign cq_in[g] = phase_reg[15:14];
            end else begin : g_chain
                assign cx_in[g] = cx_reg[g-1];
                assign cy_in[g] = cy_reg[g-1];
                assign cz_in[g] = cz_reg[g-1];
                assign cq_in[g] = cq_reg[g-1];
            end
            assign dx = cy_in[g] >>> g;
            assign dy = cx_in[g] >>> g;
            always_ff @(posedge aclk) begin
                if (adv[1+g]) begin
                    cq_reg[g] <= cq_in[g];
                    if (!cz_in[g][16]) begin
                        cx_reg[g] <= cx_in[g] - dx;
                        cy_reg[g] <= cy_in[g] + dy;
                        cz_reg[g] <= cz_in[g] - ATAN_PHASE[g];
                    end else begin
                        cx_reg[g] <= cx_in[g] + dx;
                        cy_reg[g] <= cy_in[g] - dy;
                        cz_reg[g] <= cz_in[g] + ATAN_PHASE[g];
                    end
                end
            end
        end
    endgenerate

    // Stage 15: clamp each coordinate to +-1.0 in Q.14 and map by quadrant.
    logic signed [17:0] cl_x, cl_y;
    logic signed [15:0] cos_next, sin_next, cos_reg, sin_reg;

    always_comb begin
        cl_x = cx_reg[CORDIC_STEPS-1];
        cl_y = cy_reg[CORDIC_STEPS-1];
        if (cl_x > UNIT_Q14) cl_x = UNIT_Q14;
        if (cl_x < -UNIT_Q14) cl_x = -UNIT_Q14;
        if (cl_y > UNIT_Q14) cl_y = UNIT_Q14;
        if (cl_y < -UNIT_Q14) cl_y = -UNIT_Q14;
        unique case (cq_reg[CORDIC_STEPS-1])
            2'd0: begin cos_next = 16'(cl_x);  sin_next = 16'(cl_y);  end
            2'd1: begin cos_next = 16'(-cl_y); sin_next = 16'(cl_x);  end
            2'd2: begin cos_next = 16'(-cl_x); sin_next = 16'(-cl_y); end
            default: begin cos_next = 16'(cl_y); sin_next = 16'(-cl_x); end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG]) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    // Stage 16: force and force-rate products with sin and cos.
    logic signed [39:0] p_fxc_reg, p_fzs_reg, p_fxs_reg, p_fzc_reg;
    logic signed [47:0] p_dfzs_reg, p_dfxc_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+1]) begin
            p_fxc_reg  <= pay_reg[ST_TRIG].fx * cos_reg;
            p_fzs_reg  <= pay_reg[ST_TRIG].fz * sin_reg;
            p_fxs_reg  <= pay_reg[ST_TRIG].fx * sin_reg;
            p_fzc_reg  <= pay_reg[ST_TRIG].fz * cos_reg;
            p_dfzs_reg <= pay_reg[ST_TRIG].dfz * sin_reg;
            p_dfxc_reg <= pay_reg[ST_TRIG].dfx * cos_reg;
        end
    end

    // Stage 17: Jacobian sums. The half link length is folded into the shifts.
    logic signed [40:0] tau_raw_reg, a_raw_reg;
    logic signed [48:0] b_raw_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+2]) begin
            tau_raw_reg <= 41'(p_fzs_reg) - 41'(p_fxc_reg);
            a_raw_reg   <= 41'(p_fxs_reg) + 41'(p_fzc_reg);
            b_raw_reg   <= 49'(p_dfzs_reg) - 49'(p_dfxc_reg);
        end
    end

    // Stage 18: torque to Q.16 (sign and magnitude), angular-rate product.
    logic [40:0]        tau_abs;
    logic [41:0]        tau_rnd;
    logic               tau_neg_reg;
    logic [31:0]        tau_mag_reg;
    logic signed [57:0] aw_reg;
    logic signed [48:0] b_raw2_reg;

    assign tau_abs = tau_raw_reg[40] ? 41'(-tau_raw_reg) : 41'(tau_raw_reg);
    assign tau_rnd = {1'b0, tau_abs} + 42'd64;

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+3]) begin
            tau_neg_reg <= tau_raw_reg[40];
            tau_mag_reg <= tau_rnd[38:7];
            aw_reg      <= a_raw_reg * pay_reg[ST_TRIG+2].w;
            b_raw2_reg  <= b_raw_reg;
        end
    end

    // Stage 19: raw torque rate, torque times reciprocal stiffness.
    logic signed [57:0] dtau_raw_reg;
    logic [63:0]        tq_prod_reg;
    logic               tq_neg_reg;

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+4]) begin
            dtau_raw_reg <= aw_reg + (58'(b_raw2_reg) <<< 8);
            tq_prod_reg  <= tau_mag_reg * inv_ks_reg;
            tq_neg_reg   <= tau_neg_reg;
        end
    end

    // Stage 20: round torque rate to Q.8 and tau/ks to Q.16.
    logic [57:0]        dtau_abs;
    logic [58:0]        dtau_rnd;
    logic [64:0]        tq_rnd;
    logic               dtau_neg_reg;
    logic [32:0]        dtau_mag_reg;
    logic signed [32:0] tq_reg;

    assign dtau_abs = dtau_raw_reg[57] ? 58'(-dtau_raw_reg) : 58'(dtau_raw_reg);
    assign dtau_rnd = {1'b0, dtau_abs} + (59'd1 << 22);
    assign tq_rnd   = {1'b0, tq_prod_reg} + (65'd1 << 31);

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+5]) begin
            dtau_neg_reg <= dtau_raw_reg[57];
            dtau_mag_reg <= dtau_rnd[55:23];
            tq_reg       <= tq_neg_reg ? -$signed({1'b0, tq_rnd[63:32]})
                                       : $signed({1'b0, tq_rnd[63:32]});
        end
    end

    // Stage 21: dtau/ks product, position error times kp, ks/kg product.
    logic signed [33:0] e_val;
    logic [33:0]        e_abs;
    logic [64:0]        dq_prod_reg, pt_prod_reg;
    logic               dq_neg_reg, pt_neg_reg;
    logic [63:0]        g_prod_reg;

    assign e_val = 34'(tq_reg) - (34'(pay_reg[ST_TRIG+5].d) <<< 4);
    assign e_abs = e_val[33] ? 34'(-e_val) : 34'(e_val);

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+6]) begin
            dq_prod_reg <= dtau_mag_reg * inv_ks_reg;
            dq_neg_reg  <= dtau_neg_reg;
            pt_prod_reg <= e_abs[32:0] * kp_reg;
            pt_neg_reg  <= e_val[33];
            g_prod_reg  <= ks_reg * inv_kg_reg;
        end
    end

    // Stage 22: rounding of dtau/ks, the proportional term and ks/kg.
    logic [65:0]        dq_rnd, pt_rnd;
    logic [64:0]        g_rnd;
    logic signed [42:0] dq_reg;
    logic signed [50:0] pt_reg;
    logic [31:0]        g16_reg;

    assign dq_rnd = {1'b0, dq_prod_reg} + (66'd1 << 23);
    assign pt_rnd = {1'b0, pt_prod_reg} + (66'd1 << 15);
    assign g_rnd  = {1'b0, g_prod_reg} + (65'd1 << 31);

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+7]) begin
            dq_reg  <= dq_neg_reg ? -$signed({1'b0, dq_rnd[65:24]})
                                  : $signed({1'b0, dq_rnd[65:24]});
            pt_reg  <= pt_neg_reg ? -$signed({1'b0, pt_rnd[65:16]})
                                  : $signed({1'b0, pt_rnd[65:16]});
            g16_reg <= g_rnd[63:32];
        end
    end

    // Stage 23: rate error, saturated to a 32-bit magnitude; feed-forward product.
    logic signed [43:0] ed_raw, ed_sat;
    logic [43:0]        ed_abs;
    logic [16:0]        d_abs;
    logic [31:0]        ed_mag_reg;
    logic               ed_neg_reg, ff_neg_reg;
    logic [48:0]        ff_prod_reg;
    logic signed [50:0] pt2_reg;

    assign ed_raw = 44'(dq_reg) - (44'(pay_reg[ST_TRIG+7].dd) <<< 8);
    assign d_abs  = pay_reg[ST_TRIG+7].d[16] ? 17'(-pay_reg[ST_TRIG+7].d)
                                             : 17'(pay_reg[ST_TRIG+7].d);

    always_comb begin
        priority if (ed_raw > ED_LIMIT) begin
            ed_sat = ED_LIMIT;
        end else if (ed_raw < -ED_LIMIT) begin
            ed_sat = -ED_LIMIT;
        end else begin
            ed_sat = ed_raw;
        end
        ed_abs = ed_sat[43] ? 44'(-ed_sat) : 44'(ed_sat);
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+8]) begin
            ed_mag_reg  <= ed_abs[31:0];
            ed_neg_reg  <= ed_sat[43];
            ff_prod_reg <= d_abs * g16_reg;
            ff_neg_reg  <= pay_reg[ST_TRIG+7].d[16];
            pt2_reg     <= pt_reg;
        end
    end

    // Stage 24: derivative product, feed-forward rounding.
    logic [49:0]        ff_rnd;
    logic [63:0]        dt_prod_reg;
    logic               dt_neg_reg;
    logic signed [37:0] ff_reg;
    logic signed [50:0] pt3_reg;

    assign ff_rnd = {1'b0, ff_prod_reg} + (50'd1 << 11);

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+9]) begin
            dt_prod_reg <= ed_mag_reg * kd_reg;
            dt_neg_reg  <= ed_neg_reg;
            ff_reg      <= ff_neg_reg ? -$signed({1'b0, ff_rnd[48:12]})
                                      : $signed({1'b0, ff_rnd[48:12]});
            pt3_reg     <= pt2_reg;
        end
    end

    // Stage 25: derivative term rounding.
    logic [64:0]        dt_rnd;
    logic signed [49:0] dt_reg;
    logic signed [37:0] ff2_reg;
    logic signed [50:0] pt4_reg;

    assign dt_rnd = {1'b0, dt_prod_reg} + (65'd1 << 15);

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+10]) begin
            dt_reg  <= dt_neg_reg ? -$signed({1'b0, dt_rnd[64:16]})
                                  : $signed({1'b0, dt_rnd[64:16]});
            ff2_reg <= ff_reg;
            pt4_reg <= pt3_reg;
        end
    end

    // Stage 26: exact sum of the three terms, split product with 1/kt.
    logic signed [51:0] sum_val;
    logic [51:0]        sum_abs;
    logic               sum_neg_reg;
    logic [51:0]        hi_prod_reg;
    logic [63:0]        lo_prod_reg;

    assign sum_val = 52'(ff2_reg) + 52'(pt4_reg) + 52'(dt_reg);
    assign sum_abs = sum_val[51] ? 52'(-sum_val) : 52'(sum_val);

    always_ff @(posedge aclk) begin
        if (adv[ST_TRIG+11]) begin
            sum_neg_reg <= sum_val[51];
            hi_prod_reg <= sum_abs[51:32] * inv_kt_reg;
            lo_prod_reg <= sum_abs[31:0] * inv_kt_reg;
        end
    end

    // Stage 27: current magnitude in Q8.8, saturation, output register.
    logic [64:0]        lo_rnd;
    logic [52:0]        q_val;
    logic signed [15:0] cur_next;
    logic               clip_next;
    logic               half_reg;
    logic signed [15:0] cur_reg;
    logic               clip_reg;

    assign lo_rnd = {1'b0, lo_prod_reg} + (65'd1 << 31);
    assign q_val  = 53'(hi_prod_reg) + 53'(lo_rnd[64:32]);

    always_comb begin
        if (sum_neg_reg) begin
            clip_next = q_val > 53'd32768;
            cur_next  = clip_next ? 16'sh8000 : 16'(-$signed({1'b0, q_val[15:0]}));
        end else begin
            clip_next = q_val > 53'd32767;
            cur_next  = clip_next ? 16'sh7fff : $signed(q_val[15:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[ST_LAST]) begin
            half_reg <= pay_reg[ST_LAST-1].half;
            cur_reg  <= cur_next;
            clip_reg <= clip_next;
        end
    end

    assign m_valid           = vld_reg[ST_LAST];
    assign m_result_half     = half_reg;
    assign m_motor_current   = cur_reg;
    assign m_current_clipped = clip_reg;

    // A clipped current always sits at one of the two rails.
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_current_clipped) |->
            (m_motor_current == 16'sh8000 || m_motor_current == 16'sh7fff))
        else $error("clipped current is not at a rail");

    // A draining output never holds back the input.
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // A new result only appears from a valid item in the stage before.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vld_reg[ST_LAST-1]))
        else $error("result appeared without a source item");

    // A stalled output stage keeps its item until it is taken.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result lost under backpressure");

endmodule

@@ test/tb.sv @@
// Testbench for leg_force_to_motor_current: random and directed force requests
// checked against a fixed-point predictor of the current law. Depends on lfmc_pkg.
`timescale 1ns / 1ps

module tb;
    import lfmc_pkg::*;

    // Longest expected run of cycles with no handshake on any channel.
    // This covers a full sender gap, a full receiver stall, the pipeline
    // latency and the quiet time before a register write, with a wide margin.
    localparam int STALL_LIMIT = 4000;
    // Quiet time after the last result, sized from the pipeline latency.
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic               half;
        logic signed [23:0] fx;
        logic signed [23:0] fz;
        logic signed [31:0] dfx;
        logic signed [31:0] dfz;
        logic signed [15:0] leg_ang;
        logic signed [15:0] motor_ang;
        logic signed [15:0] leg_rate;
        logic signed [15:0] motor_rate;
        logic signed [15:0] pitch;
        logic signed [15:0] pitch_rate;
    } force_request_t;

    typedef struct {
        logic               half;
        logic signed [15:0] current;
        logic               clipped;
    } motor_current_t;

    localparam int ATAN_STEP [14] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                      81, 41, 20, 10, 5, 3, 1};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_leg_half = 1'b0;
    logic signed [23:0] s_force_x = '0;
    logic signed [23:0] s_force_z = '0;
    logic signed [31:0] s_force_x_rate = '0;
    logic signed [31:0] s_force_z_rate = '0;
    logic signed [15:0] s_leg_angle = '0;
    logic signed [15:0] s_motor_angle = '0;
    logic signed [15:0] s_leg_rate = '0;
    logic signed [15:0] s_motor_rate = '0;
    logic signed [15:0] s_body_pitch = '0;
    logic signed [15:0] s_body_pitch_rate = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_result_half;
    logic signed [15:0] m_motor_current;
    logic               m_current_clipped;

    // Our own copy of the gain registers, indexed by register index.
    bit [31:0]      gains [6];
    motor_current_t pending_currents [$];
    bit             failed = 1'b0;
    bit             sender_burst = 1'b0;
    int             quiet_cycles = 0;

    leg_force_to_motor_current dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Product rounded to nearest, ties away from zero on the magnitude.
    function automatic longint round_shift(longint a, bit [63:0] b, int sh);
        bit [63:0] mag;
        bit [63:0] p;
        mag = (a < 0) ? 64'(-a) : 64'(a);
        p = (mag * b + (64'd1 << (sh - 1))) >> sh;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    // Computes the saturated motor current for one request under the
    // current gain settings.
    function automatic motor_current_t motor_current_of(force_request_t r);
        motor_current_t o;
        longint th, fx, fz, dfx, dfz, d, dd, w, c, s;
        longint tau16, dtau8, tq, dq, ff, e, pt, ed, dt, sum;
        bit [63:0] u, g16, mag, q, b;
        int x, y, z, dx, dy, cx, sy;
        bit [15:0] phase;
        fx  = r.fx;
        fz  = r.fz;
        dfx = r.dfx;
        dfz = r.dfz;
        th  = longint'(r.leg_ang) + longint'(r.pitch);
        // The angle becomes a 16-bit phase, one turn being 65536.
        u = 64'(th * 166886);
        phase = 16'((u + 64'd32768) >> 16);
        x = 9949;
        y = 0;
        z = int'(phase[13:0]);
        for (int i = 0; i < 14; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        cx = (x > 16384) ? 16384 : ((x < -16384) ? -16384 : x);
        sy = (y > 16384) ? 16384 : ((y < -16384) ? -16384 : y);
        case (phase[15:14])
            2'd0: begin c = cx;  s = sy;  end
            2'd1: begin c = -sy; s = cx;  end
            2'd2: begin c = -cx; s = -sy; end
            default: begin c = sy; s = -cx; end
        endcase
        w = longint'(r.leg_rate) + longint'(r.pitch_rate);
        tau16 = round_shift(-fx * c + fz * s, 64'd1, 7);
        dtau8 = round_shift((fx * s + fz * c) * w + (dfz * s - dfx * c) * 256, 64'd1, 23);
        tq = round_shift(tau16, 64'(gains[REG_INV_STIFFNESS]), 32);
        dq = round_shift(dtau8, 64'(gains[REG_INV_STIFFNESS]), 24);
        d  = longint'(r.motor_ang) - longint'(r.leg_ang);
        dd = longint'(r.motor_rate) - longint'(r.leg_rate);
        g16 = (64'(gains[REG_SPRING_STIFFNESS]) * 64'(gains[REG_INV_GEAR_GAIN])
               + 64'h8000_0000) >> 32;
        ff = round_shift(d, g16, 12);
        e  = tq - d * 16;
        pt = round_shift(e, 64'(gains[REG_PROP_GAIN]), 16);
        // The derivative error saturates before the kd multiply.
        ed = dq - dd * 256;
        if (ed > 64'sd4294967295) ed = 64'sd4294967295;
        if (ed < -64'sd4294967295) ed = -64'sd4294967295;
        dt = round_shift(ed, 64'(gains[REG_DERIV_GAIN]), 16);
        sum = ff + pt + dt;
        b = 64'(gains[REG_INV_TORQUE_CONST]);
        mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        q = (mag >> 32) * b + (((mag & 64'hFFFF_FFFF) * b + 64'h8000_0000) >> 32);
        o.half = r.half;
        o.clipped = 1'b0;
        if (sum < 0) begin
            if (q > 64'd32768) begin
                o.current = -16'sd32768;
                o.clipped = 1'b1;
            end else begin
                o.current = 16'(-longint'(q));
            end
        end else begin
            if (q > 64'd32767) begin
                o.current = 16'sd32767;
                o.clipped = 1'b1;
            end else begin
                o.current = 16'(q);
            end
        end
        return o;
    endfunction

    function automatic force_request_t random_request();
        force_request_t r;
        r.half       = 1'($urandom);
        r.fx         = 24'($urandom);
        r.fz         = 24'($urandom);
        r.dfx        = $urandom;
        r.dfz        = $urandom;
        r.leg_ang    = 16'($urandom);
        r.motor_ang  = 16'($urandom);
        r.leg_rate   = 16'($urandom);
        r.motor_rate = 16'($urandom);
        r.pitch      = 16'($urandom);
        r.pitch_rate = 16'($urandom);
        // Most requests stay near a working point so that the current does
        // not simply saturate; the rest use the full field ranges.
        if ($urandom_range(0, 3) != 0) begin
            r.fx         = 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            r.fz         = 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            r.dfx        = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            r.dfz        = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            r.motor_ang  = r.leg_ang + 16'(int'($urandom_range(0, 64)) - 32);
            r.motor_rate = r.leg_rate + 16'(int'($urandom_range(0, 512)) - 256);
        end
        return r;
    endfunction

    // Sends one request after a random gap, holding valid and payload
    // until the block accepts it, and records the expected current.
    task automatic send_request(force_request_t r);
        int gap;
        if ($urandom_range(0, 29) == 0) sender_burst = ~sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_leg_half        <= r.half;
        s_force_x         <= r.fx;
        s_force_z         <= r.fz;
        s_force_x_rate    <= r.dfx;
        s_force_z_rate    <= r.dfz;
        s_leg_angle       <= r.leg_ang;
        s_motor_angle     <= r.motor_ang;
        s_leg_rate        <= r.leg_rate;
        s_motor_rate      <= r.motor_rate;
        s_body_pitch      <= r.pitch;
        s_body_pitch_rate <= r.pitch_rate;
        do @(posedge aclk); while (!s_ready);
        pending_currents.push_back(motor_current_of(r));
    endtask

    // Lets the pipeline empty completely so a register write is safe.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_currents.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Each write deasserts cfg_valid before the task returns, leaving the configuration channel idle.
    task automatic write_gain(logic [2:0] index, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Indexes beyond the register list are ignored by the block.
        if (index <= REG_INV_TORQUE_CONST) gains[index] = value;
        @(posedge aclk);
    endtask

    task automatic write_all_gains(logic [31:0] value [6]);
        wait_idle();
        for (int i = 0; i < 6; i++) write_gain(3'(i), value[i]);
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) send_request(random_request());
    endtask

    // Field extremes, both halves, both signs of the angles and a large
    // derivative error that must saturate before the kd multiply.
    task automatic test_directed();
        force_request_t r;
        r = '{1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
        send_request(r);
        r.half = 1'b1;
        send_request(r);
        r = '{1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_request(r);
        r = '{1'b0, 24'sh800000, 24'sh800000, 32'sh80000000, 32'sh80000000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_request(r);
        r = '{1'b0, 24'sh7FFFFF, 24'sh800000, 32'sh80000000, 32'sh7FFFFFFF,
              16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
        send_request(r);
        // A sweep of the leg angle through all four quadrants.
        for (int k = 0; k < 8; k++) begin
            r = '{1'(k), 24'sd25600, 24'sd51200, 32'sd2560, -32'sd2560,
                  16'(k * 3217 - 12868), 16'(k * 3217 - 12800), 16'sd256, 16'sd300,
                  16'sd0, 16'sd0};
            send_request(r);
        end
        // Motor lagging and leading the leg, with and without force.
        r = '{1'b1, '0, '0, '0, '0, 16'sd1000, 16'sh7FFF, '0, 16'sh7FFF, '0, '0};
        send_request(r);
        r = '{1'b0, '0, '0, '0, '0, 16'sd1000, 16'sh8000, '0, 16'sh8000, '0, '0};
        send_request(r);
        r = '{1'b0, 24'sd256, 24'sd256, 32'sd256, 32'sd256, 16'sd804, 16'sd805,
              16'sd10, 16'sd11, -16'sd804, -16'sd10};
        send_request(r);
    endtask

    task automatic test_default_gains();
        send_random(140);
    endtask

    task automatic test_max_gains();
        logic [31:0] v [6];
        v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF};
        write_all_gains(v);
        test_directed();
        send_random(40);
    endtask

    task automatic test_zero_gains();
        logic [31:0] v [6];
        v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        write_all_gains(v);
        send_random(30);
        // Writes to unused indexes must leave the gains alone.
        wait_idle();
        write_gain(3'd6, 32'hFFFF_FFFF);
        write_gain(3'd7, 32'hA5A5_A5A5);
        send_random(10);
    endtask

    task automatic test_random_gains();
        logic [31:0] v [6];
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 6; i++) v[i] = $urandom;
            // Keep some settings close to the working values.
            if (k[0]) begin
                v[REG_PROP_GAIN]  = $urandom_range(0, 32'd131072000);
                v[REG_DERIV_GAIN] = $urandom_range(0, 32'd2097152);
            end
            write_all_gains(v);
            send_random(35);
        end
    endtask

    task automatic test_reset_gains();
        logic [31:0] v [6];
        v = '{RST_PROP_GAIN, RST_DERIV_GAIN, RST_SPRING_STIFFNESS,
              RST_INV_STIFFNESS, RST_INV_GEAR_GAIN, RST_INV_TORQUE_CONST};
        write_all_gains(v);
        send_random(30);
    endtask

    // The receiver stalls a random number of cycles before each result,
    // with stretches where it takes every result at once.
    initial begin
        int stall;
        bit burst;
        burst = 1'b0;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 29) == 0) burst = ~burst;
            stall = burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Each accepted result is compared with the oldest expected current.
    always @(posedge aclk) begin
        motor_current_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_currents.size() == 0) begin
                $error("motor current result with no request outstanding");
                failed = 1'b1;
            end else begin
                want = pending_currents.pop_front();
                if (m_result_half !== want.half) begin
                    $error("result_half: expected %0d, actual %0d", want.half, m_result_half);
                    failed = 1'b1;
                end
                if (m_motor_current !== want.current) begin
                    $error("motor_current: expected %0d, actual %0d",
                           want.current, m_motor_current);
                    failed = 1'b1;
                end
                if (m_current_clipped !== want.clipped) begin
                    $error("current_clipped: expected %0d, actual %0d",
                           want.clipped, m_current_clipped);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run if no channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        gains = '{RST_PROP_GAIN, RST_DERIV_GAIN, RST_SPRING_STIFFNESS,
                  RST_INV_STIFFNESS, RST_INV_GEAR_GAIN, RST_INV_TORQUE_CONST};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_default_gains();
        test_max_gains();
        test_zero_gains();
        test_random_gains();
        test_reset_gains();

        wait_idle();
        if (!failed) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
